@@ src/pbra_pkg.sv @@
// Shared types and constants for the page bitmap run allocator.
`default_nettype none
package pbra_pkg;
   localparam int MapPagesDefault    = 64;
   localparam int PageBytesDefault   = 512;
   localparam int NumMapsDefault     = 16;
   localparam int MaxRunPagesDefault = 64;
   localparam int COUNT_MAX          = 2047;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN_RD,
      ST_SCAN_CAND,
      ST_SCAN_CHK,
      ST_SCAN_NEXT,
      ST_DECIDE,
      ST_SET,
      ST_FREE_PREP,
      ST_CLEAR,
      ST_DONE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic scan_rd;
      logic scan_cand;
      logic scan_chk;
      logic scan_next;
      logic decide;
      logic set_step;
      logic free_prep;
      logic clear_step;
      logic done;
   } ctrl_type;

   typedef struct packed {
      logic is_free;
      logic zero_size;
      logic too_long;
      logic no_scan;
      logic avail_empty;
      logic chk_end;
      logic chk_fail;
      logic maps_end;
      logic walk_end;
      logic fail;
   } stat_type;
endpackage
`default_nettype wire

@@ src/pbra_ctrl.sv @@
// Sequencer for the page bitmap run allocator.
`default_nettype none
module pbra_ctrl
   import pbra_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output ctrl_type      ctrl
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            if (stat.is_free) state_in = ST_FREE_PREP;
            else if (stat.zero_size || stat.too_long) state_in = ST_DONE;
            else if (stat.no_scan) state_in = ST_DECIDE;
            else state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_CAND;
         ST_SCAN_CAND: begin
            if (stat.avail_empty) state_in = ST_SCAN_NEXT;
            else state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (stat.chk_fail) state_in = ST_SCAN_CAND;
            else if (stat.chk_end) state_in = ST_DECIDE;
         end
         ST_SCAN_NEXT: begin
            if (stat.maps_end) state_in = ST_DECIDE;
            else state_in = ST_SCAN_RD;
         end
         ST_DECIDE: begin
            if (stat.fail) state_in = ST_DONE;
            else state_in = ST_SET;
         end
         ST_SET: begin
            if (stat.walk_end) state_in = ST_DONE;
         end
         ST_FREE_PREP: state_in = ST_CLEAR;
         ST_CLEAR: begin
            if (stat.walk_end) state_in = ST_DONE;
         end
         ST_DONE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.load = req_valid;
         end
         ST_PREP:      ctrl.prep = 1'b1;
         ST_SCAN_RD:   ctrl.scan_rd = 1'b1;
         ST_SCAN_CAND: ctrl.scan_cand = 1'b1;
         ST_SCAN_CHK:  ctrl.scan_chk = 1'b1;
         ST_SCAN_NEXT: ctrl.scan_next = 1'b1;
         ST_DECIDE:    ctrl.decide = 1'b1;
         ST_SET:       ctrl.set_step = 1'b1;
         ST_FREE_PREP: ctrl.free_prep = 1'b1;
         ST_CLEAR:     ctrl.clear_step = 1'b1;
         ST_DONE:      ctrl.done = 1'b1;
         ST_RESP:      rsp_valid = 1'b1;
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request ready while busy");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid)
      else $error("response missing after done");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped");
`endif
endmodule
`default_nettype wire

@@ src/pbra_dp.sv @@
// Bitmap storage, scan and run walk datapath of the page bitmap run allocator.
`default_nettype none
module pbra_dp
   import pbra_pkg::*;
#(
   parameter int MAP_PAGES     = MapPagesDefault,
   parameter int PAGE_BYTES    = PageBytesDefault,
   parameter int NUM_MAPS      = NumMapsDefault,
   parameter int MAX_RUN_PAGES = MaxRunPagesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire ctrl_type    ctrl,
   output stat_type         stat,
   input  wire logic        req_cmd,
   input  wire logic [15:0] req_size_bytes,
   input  wire logic [19:0] req_run_offset,
   output logic             rsp_status,
   output logic [19:0]      rsp_alloc_offset,
   output logic [10:0]      rsp_used_count
);
   localparam int TOTAL = NUM_MAPS * MAP_PAGES;
   localparam int PW    = $clog2(TOTAL + 1) + 8;
   localparam int MW    = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;
   localparam int AW    = $clog2(NUM_MAPS + 1);
   localparam int BW    = (MAP_PAGES > 1) ? $clog2(MAP_PAGES) : 1;
   localparam int SHW   = $clog2(PAGE_BYTES);

   logic [MAP_PAGES-1:0] used_ff [NUM_MAPS];
   logic [MAP_PAGES-1:0] head_ff [NUM_MAPS];
   logic [AW-1:0]  active_ff;
   logic [MW-1:0]  start_ff;
   logic [10:0]    inuse_ff;

   logic           cmd_ff;
   logic [15:0]    size_ff;
   logic [19:0]    off_ff;
   logic [PW-1:0]  need_ff;
   logic [AW-1:0]  iter_ff;
   logic [MW-1:0]  m_ff;
   logic [MAP_PAGES-1:0] avail_ff;
   logic [PW-1:0]  base_ff;
   logic [PW-1:0]  j_ff;
   logic [PW-1:0]  p_ff;
   logic           found_ff;
   logic [PW-1:0]  idx_ff;
   logic           status_ff;
   logic [19:0]    aoff_ff;

   logic [PW-1:0]  need_c, cnt_c, chk_p, first_c;
   logic [AW:0]    mnext;
   logic [BW-1:0]  low_c;
   logic [MW-1:0]  pm;
   logic [BW-1:0]  pb;
   logic           chk_used, chk_block, chk_out_active, chk_cap;
   logic [PW:0]    sum_c;

   assign need_c  = PW'((32'(req_size_bytes) + 32'(PAGE_BYTES - 1)) >> SHW);
   assign cnt_c   = PW'(32'(size_ff) >> SHW);
   assign first_c = PW'((32'(off_ff) >> SHW) - 32'd1);

   always_comb begin
      low_c = '0;
      for (int k = MAP_PAGES - 1; k >= 0; k--) begin
         if (avail_ff[k]) low_c = BW'(k);
      end
   end

   assign chk_p = base_ff + j_ff;
   assign chk_out_active = (32'(chk_p) / MAP_PAGES) >= 32'(active_ff);
   assign chk_used = ((32'(chk_p) / MAP_PAGES) >= NUM_MAPS) ? 1'b1 :
      used_ff[MW'(32'(chk_p) / MAP_PAGES)][BW'(32'(chk_p) % MAP_PAGES)];
   assign chk_block = (j_ff < need_ff) && !chk_out_active && chk_used;
   assign sum_c = (PW+1)'(base_ff) + (PW+1)'(need_ff);
   assign chk_cap = sum_c > (PW+1)'(TOTAL);

   assign pm = MW'(32'(p_ff) / MAP_PAGES);
   assign pb = BW'(32'(p_ff) % MAP_PAGES);
   assign mnext = (AW+1)'(m_ff) + (AW+1)'(1);

   always_comb begin
      stat.is_free     = cmd_ff == CMD_FREE;
      stat.zero_size   = need_ff == '0;
      stat.too_long    = need_ff > PW'(MAX_RUN_PAGES);
      stat.no_scan     = (active_ff == '0) ||
         (32'(inuse_ff) > 32'(active_ff) * MAP_PAGES);
      stat.avail_empty = avail_ff == '0;
      stat.chk_end     = (j_ff >= need_ff) || chk_out_active;
      stat.chk_fail    = chk_block || (((j_ff >= need_ff) || chk_out_active) && chk_cap);
      stat.maps_end    = (iter_ff + AW'(1)) >= active_ff;
      stat.walk_end    = (j_ff >= need_ff) || (32'(p_ff) >= TOTAL);
      stat.fail        = !found_ff && ((PW+1)'(idx_ff) + (PW+1)'(need_ff) > (PW+1)'(TOTAL));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_MAPS; k++) begin
            used_ff[k] <= '0;
            head_ff[k] <= '0;
         end
         active_ff <= '0;
         start_ff  <= '0;
         inuse_ff  <= '0;
      end else begin
         if (ctrl.load) begin
            cmd_ff    <= req_cmd;
            size_ff   <= req_size_bytes;
            off_ff    <= req_run_offset;
            need_ff   <= need_c;
            status_ff <= 1'b0;
            aoff_ff   <= '0;
         end
         if (ctrl.prep) begin
            iter_ff  <= '0;
            found_ff <= 1'b0;
            idx_ff   <= PW'(32'(active_ff) * MAP_PAGES);
            m_ff     <= start_ff;
            if (cmd_ff == CMD_ALLOC && need_ff > PW'(MAX_RUN_PAGES)) status_ff <= 1'b1;
         end
         if (ctrl.scan_rd) avail_ff <= ~used_ff[m_ff];
         if (ctrl.scan_cand && avail_ff != '0) begin
            base_ff <= PW'(32'(m_ff) * MAP_PAGES + 32'(low_c));
            avail_ff <= avail_ff & (avail_ff - MAP_PAGES'(1));
            j_ff <= PW'(1);
         end
         if (ctrl.scan_chk) begin
            if (!stat.chk_fail && stat.chk_end) begin
               found_ff <= 1'b1;
               idx_ff   <= base_ff;
               start_ff <= m_ff;
            end else begin
               j_ff <= j_ff + PW'(1);
            end
         end
         if (ctrl.scan_next) begin
            iter_ff <= iter_ff + AW'(1);
            m_ff <= (mnext >= (AW+1)'(active_ff)) ? '0 : MW'(mnext);
         end
         if (ctrl.decide) begin
            j_ff <= '0;
            p_ff <= idx_ff;
            if (stat.fail) status_ff <= 1'b1;
            else begin
               aoff_ff <= 20'((32'(idx_ff) + 32'd1) * PAGE_BYTES);
               inuse_ff <= (32'(inuse_ff) + 32'(need_ff) > COUNT_MAX) ? 11'(COUNT_MAX) :
                  11'(32'(inuse_ff) + 32'(need_ff));
            end
         end
         if (ctrl.set_step && !stat.walk_end) begin
            used_ff[pm][pb] <= 1'b1;
            if (j_ff == '0) head_ff[pm][pb] <= 1'b1;
            if (32'(pm) >= 32'(active_ff)) active_ff <= AW'(32'(pm) + 1);
            j_ff <= j_ff + PW'(1);
            p_ff <= p_ff + PW'(1);
         end
         if (ctrl.free_prep) begin
            inuse_ff <= (32'(cnt_c) > 32'(inuse_ff)) ? '0 : 11'(32'(inuse_ff) - 32'(cnt_c));
            j_ff <= '0;
            need_ff <= (off_ff < 20'(PAGE_BYTES)) ? '0 : cnt_c;
            p_ff <= first_c;
         end
         if (ctrl.clear_step && !stat.walk_end) begin
            used_ff[pm][pb] <= 1'b0;
            if (j_ff == '0) head_ff[pm][pb] <= 1'b0;
            j_ff <= j_ff + PW'(1);
            p_ff <= p_ff + PW'(1);
         end
         if (ctrl.done) rsp_used_count <= inuse_ff;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_alloc_offset = aoff_ff;

`ifndef SYNTHESIS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      ctrl.done |-> (inuse_ff <= 11'(COUNT_MAX)))
      else $error("count overflow");
   a_fail_no_offset: assert property (@(posedge clock) disable iff (reset)
      (ctrl.done && status_ff) |-> (aoff_ff == '0))
      else $error("offset on failure");
   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      32'(active_ff) <= NUM_MAPS)
      else $error("active maps out of range");
`endif
endmodule
`default_nettype wire

@@ src/page_bitmap_run_allocator_unit.sv @@
// Top level of the page bitmap run allocator.
// Sequence: an alloc preps, scans the maps (reading each map visited, taking each free
//   candidate and checking its pages), decides, then sets the run's pages; a zero-size or
//   overlong alloc skips to the response; a free preps, then clears the run's pages.
// Handshake: one transaction at a time; the next one is taken the cycle after the
//   response is accepted.
// Reset: synchronous; clears all used and head maps, counts and the scan start.
`default_nettype none
module page_bitmap_run_allocator_unit
   import pbra_pkg::*;
#(
   parameter int MAP_PAGES     = MapPagesDefault,
   parameter int PAGE_BYTES    = PageBytesDefault,
   parameter int NUM_MAPS      = NumMapsDefault,
   parameter int MAX_RUN_PAGES = MaxRunPagesDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_cmd,
   input  wire logic [15:0] req_size_bytes,
   input  wire logic [19:0] req_run_offset,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_status,
   output logic [19:0]      rsp_alloc_offset,
   output logic [10:0]      rsp_used_count
);
   ctrl_type ctrl;
   stat_type stat;

   pbra_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .stat, .ctrl
   );

   pbra_dp #(
      .MAP_PAGES(MAP_PAGES), .PAGE_BYTES(PAGE_BYTES),
      .NUM_MAPS(NUM_MAPS), .MAX_RUN_PAGES(MAX_RUN_PAGES)
   ) u_dp (
      .clock, .reset, .ctrl, .stat, .req_cmd, .req_size_bytes, .req_run_offset,
      .rsp_status, .rsp_alloc_offset, .rsp_used_count
   );
endmodule
`default_nettype wire
